// ===== design/ipv4hc_pkg.sv =====
// Shared types and constants for the IPv4 header receive checker.
// Used by the header parser, the output buffer, the top level and the checker.
package ipv4hc_pkg;

	typedef enum logic [3:0] {
		VERDICT_ICMP        = 4'd0,
		VERDICT_UDP_UNREACH = 4'd1,
		VERDICT_TCP         = 4'd2,
		VERDICT_OTHER       = 4'd3,
		VERDICT_FRAGMENT    = 4'd4,
		VERDICT_BAD_VERSION = 4'd5,
		VERDICT_BAD_SIZE    = 4'd6,
		VERDICT_BAD_CSUM    = 4'd7,
		VERDICT_NOT_OURS    = 4'd8
	} verdict_t;

	// configuration register indexes
	localparam logic REG_LOCAL_ADDRESS = 1'b0;
	localparam logic REG_SUBNET_MASK   = 1'b1;

	localparam logic [3:0]  IP_VERSION       = 4'd4;
	localparam logic [3:0]  MIN_IHL_WORDS    = 4'd5;
	localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
	localparam logic [15:0] CSUM_GOOD        = 16'hFFFF;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	typedef struct packed {
		verdict_t     verdict;
		logic [7:0]   protocol_number;
		logic [31:0]  source_address;
		logic [15:0]  total_length;
		logic [5:0]   header_bytes;
		logic [15:0]  identification;
		logic [15:0]  fragment_offset_bytes;
		logic         more_fragments;
	} result_t;

endpackage

// ===== design/ipv4_header_receive_checker_top.sv =====
// IPv4 header receive checker, top level.
// Instantiates ipv4hc_parse and ipv4hc_outbuf; uses ipv4hc_pkg.
//
// Takes one 32-bit header word per clock while in_ready is high, and gives at
// most one verdict per header. A word is processed in the cycle it is accepted;
// its verdict, if it decides one, sits in the output register from the next
// cycle, or in the skid entry behind a result that downstream is still holding
// off. The single-pass parser sits between the input port and the two-entry
// output buffer; input ready drops only when both buffer entries hold results
// that downstream has not taken.
module ipv4_header_receive_checker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] header_word,
	input  logic        first_word,
	input  logic [15:0] frame_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  verdict,
	output logic [7:0]  protocol_number,
	output logic [31:0] source_address,
	output logic [15:0] total_length,
	output logic [5:0]  header_bytes,
	output logic [15:0] identification,
	output logic [15:0] fragment_offset_bytes,
	output logic        more_fragments
);

	logic [31:0]         local_address_q;
	logic [31:0]         subnet_mask_q;
	logic                word_fire;
	logic                res_push;
	logic                space;
	ipv4hc_pkg::result_t res;
	ipv4hc_pkg::result_t out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q <= 32'd0;
			subnet_mask_q   <= 32'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ipv4hc_pkg::REG_LOCAL_ADDRESS: local_address_q <= cfg_data;
				ipv4hc_pkg::REG_SUBNET_MASK:   subnet_mask_q   <= cfg_data;
			endcase
		end
	end

	assign in_ready  = space;
	assign word_fire = in_valid && in_ready;

	ipv4hc_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.word_fire     (word_fire),
		.header_word   (header_word),
		.first_word    (first_word),
		.frame_length  (frame_length),
		.local_address (local_address_q),
		.subnet_mask   (subnet_mask_q),
		.res_push      (res_push),
		.res           (res)
	);

	ipv4hc_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign verdict               = out_data.verdict;
	assign protocol_number       = out_data.protocol_number;
	assign source_address        = out_data.source_address;
	assign total_length          = out_data.total_length;
	assign header_bytes          = out_data.header_bytes;
	assign identification        = out_data.identification;
	assign fragment_offset_bytes = out_data.fragment_offset_bytes;
	assign more_fragments        = out_data.more_fragments;

endmodule

// ===== design/ipv4hc_parse.sv =====
// Header parser: captures fields word by word, keeps the ones'-complement sum
// and decides the verdict. Depends on ipv4hc_pkg.
module ipv4hc_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                word_fire,
	input  logic [31:0]         header_word,
	input  logic                first_word,
	input  logic [15:0]         frame_length,
	input  logic [31:0]         local_address,
	input  logic [31:0]         subnet_mask,
	output logic                res_push,
	output ipv4hc_pkg::result_t res
);

	logic        active_q;
	logic [3:0]  word_index_q;
	logic [3:0]  hwc_q;
	logic [15:0] csum_q;
	logic [15:0] total_len_q;
	logic [15:0] ident_q;
	logic [15:0] frag_q;
	logic [7:0]  proto_q;
	logic        csum_present_q;
	logic [31:0] source_q;
	logic [31:0] dest_q;
	logic [15:0] frame_len_q;

	logic        take;
	logic [3:0]  idx;
	logic [15:0] flen;
	logic [15:0] csum_n;
	logic [3:0]  hwc_n;
	logic [15:0] total_len_n;
	logic [15:0] ident_n;
	logic [15:0] frag_n;
	logic [7:0]  proto_n;
	logic        csum_present_n;
	logic [31:0] source_n;
	logic [31:0] dest_n;
	logic        early_fail;
	logic        last_word;
	logic        dest_ok;
	ipv4hc_pkg::verdict_t verdict_n;

	// end-around-carry add of one halfword
	function automatic logic [15:0] csum_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		begin
			s = {1'b0, a} + {1'b0, b};
			csum_add = s[15:0] + {15'd0, s[16]};
		end
	endfunction

	always_comb begin
		logic [15:0] csum_base;
		logic [15:0] csum_mid;
		logic [31:0] host_bits;
		take       = first_word || active_q;
		idx        = first_word ? 4'd0 : word_index_q;
		flen       = first_word ? frame_length : frame_len_q;
		csum_base  = first_word ? 16'd0 : csum_q;
		csum_mid   = csum_add(csum_base, header_word[31:16]);
		csum_n     = csum_add(csum_mid, header_word[15:0]);

		hwc_n          = first_word ? 4'd0 : hwc_q;
		total_len_n    = first_word ? 16'd0 : total_len_q;
		ident_n        = first_word ? 16'd0 : ident_q;
		frag_n         = first_word ? 16'd0 : frag_q;
		proto_n        = first_word ? 8'd0 : proto_q;
		csum_present_n = first_word ? 1'b0 : csum_present_q;
		source_n       = first_word ? 32'd0 : source_q;
		dest_n         = first_word ? 32'd0 : dest_q;

		unique case (idx)
			4'd0: begin
				hwc_n       = header_word[27:24];
				total_len_n = header_word[15:0];
			end
			4'd1: begin
				ident_n = header_word[31:16];
				frag_n  = header_word[15:0];
			end
			4'd2: begin
				proto_n        = header_word[23:16];
				csum_present_n = header_word[15:0] != 16'd0;
			end
			4'd3: source_n = header_word;
			4'd4: dest_n   = header_word;
			default: ;
		endcase

		host_bits = ~subnet_mask;
		dest_ok   = (dest_n == 32'hFFFF_FFFF)
			|| (((dest_n & host_bits) == host_bits)
				&& ((dest_n & subnet_mask) == (local_address & subnet_mask)))
			|| (dest_n == local_address);

		early_fail = 1'b0;
		last_word  = ({1'b0, idx} + 5'd1) >= {1'b0, hwc_n};
		verdict_n  = ipv4hc_pkg::VERDICT_OTHER;
		priority if (idx == 4'd0 && header_word[31:28] != ipv4hc_pkg::IP_VERSION) begin
			early_fail = 1'b1;
			verdict_n  = ipv4hc_pkg::VERDICT_BAD_VERSION;
		end else if (idx == 4'd0 && (hwc_n < ipv4hc_pkg::MIN_IHL_WORDS
				|| total_len_n < ipv4hc_pkg::MIN_HEADER_BYTES
				|| flen < total_len_n)) begin
			early_fail = 1'b1;
			verdict_n  = ipv4hc_pkg::VERDICT_BAD_SIZE;
		end else if (csum_present_n && csum_n != ipv4hc_pkg::CSUM_GOOD) begin
			verdict_n = ipv4hc_pkg::VERDICT_BAD_CSUM;
		end else if (!dest_ok) begin
			verdict_n = ipv4hc_pkg::VERDICT_NOT_OURS;
		end else if (frag_n[13:0] != 14'd0) begin
			verdict_n = ipv4hc_pkg::VERDICT_FRAGMENT;
		end else if (proto_n == ipv4hc_pkg::PROTO_ICMP) begin
			verdict_n = ipv4hc_pkg::VERDICT_ICMP;
		end else if (proto_n == ipv4hc_pkg::PROTO_UDP) begin
			verdict_n = ipv4hc_pkg::VERDICT_UDP_UNREACH;
		end else if (proto_n == ipv4hc_pkg::PROTO_TCP) begin
			verdict_n = ipv4hc_pkg::VERDICT_TCP;
		end else begin
			verdict_n = ipv4hc_pkg::VERDICT_OTHER;
		end
	end

	assign res_push = word_fire && take && (early_fail || last_word);

	always_comb begin
		res.verdict               = verdict_n;
		res.protocol_number       = proto_n;
		res.source_address        = source_n;
		res.total_length          = total_len_n;
		res.header_bytes          = {hwc_n, 2'b00};
		res.identification        = ident_n;
		res.fragment_offset_bytes = {frag_n[12:0], 3'b000};
		res.more_fragments        = frag_n[13];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			word_index_q <= 4'd0;
		end else if (word_fire && take) begin
			// drop the header once its verdict is out
			active_q     <= !(early_fail || last_word);
			word_index_q <= idx + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (word_fire && take) begin
			hwc_q          <= hwc_n;
			csum_q         <= csum_n;
			total_len_q    <= total_len_n;
			ident_q        <= ident_n;
			frag_q         <= frag_n;
			proto_q        <= proto_n;
			csum_present_q <= csum_present_n;
			source_q       <= source_n;
			dest_q         <= dest_n;
			frame_len_q    <= flen;
		end
	end

endmodule

// ===== design/ipv4hc_outbuf.sv =====
// Two-entry result buffer: output register plus skid register, so the input
// side keeps moving while a result waits. Depends on ipv4hc_pkg.
module ipv4hc_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ipv4hc_pkg::result_t push_data,
	output logic                space,
	output logic                out_valid,
	input  logic                out_ready,
	output ipv4hc_pkg::result_t out_data
);

	logic                out_valid_q;
	logic                skid_valid_q;
	ipv4hc_pkg::result_t out_q;
	ipv4hc_pkg::result_t skid_q;

	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			// hold the word until the output register frees
			skid_q <= push_data;
		end
	end

endmodule

// ===== design/ipv4hc_checker.sv =====
// Port-level checks for the IPv4 header receive checker, bound to the top level.
// Depends on ipv4hc_pkg.
module ipv4hc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  verdict,
	input logic [7:0]  protocol_number,
	input logic [5:0]  header_bytes,
	input logic [15:0] fragment_offset_bytes,
	input logic        more_fragments
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(verdict))
		else $error("result word changed while stalled");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> verdict <= ipv4hc_pkg::VERDICT_NOT_OURS)
		else $error("verdict code out of range");

	a_scaled_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> header_bytes[1:0] == 2'b00 && fragment_offset_bytes[2:0] == 3'b000)
		else $error("scaled length fields misaligned");

	a_dispatch_unfragmented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict < ipv4hc_pkg::VERDICT_FRAGMENT
		|-> !more_fragments && fragment_offset_bytes == 16'd0
			&& header_bytes >= 6'd20)
		else $error("protocol dispatch on a fragment or short header");

	a_icmp_proto: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == ipv4hc_pkg::VERDICT_ICMP
		|-> protocol_number == ipv4hc_pkg::PROTO_ICMP)
		else $error("ICMP verdict with another protocol number");

endmodule

bind ipv4_header_receive_checker_top ipv4hc_checker u_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.out_valid             (out_valid),
	.out_ready             (out_ready),
	.verdict               (verdict),
	.protocol_number       (protocol_number),
	.header_bytes          (header_bytes),
	.fragment_offset_bytes (fragment_offset_bytes),
	.more_fragments        (more_fragments)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for ipv4_header_receive_checker_top: a header predictor with a
// verdict queue, valid/ready drivers with random gaps and stalls, and register phases.
// Depends on ipv4hc_pkg and the RTL under design/.
`timescale 1ns / 100ps

class header_ledger;
	logic [31:0] local_addr;
	logic [31:0] net_mask;
	logic [3:0]  word_idx;
	logic [3:0]  ihl_words;
	logic [16:0] csum_acc;
	logic [15:0] tot_len;
	logic [15:0] ident;
	logic [15:0] frag_field;
	logic [15:0] frame_len;
	logic [7:0]  proto;
	logic        csum_given;
	logic        in_header;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	ipv4hc_pkg::result_t verdicts_due[$];
	int          mismatches;

	function new();
		local_addr = '0;
		net_mask = '0;
		in_header = 1'b0;
		mismatches = 0;
		clear_header();
	endfunction

	static function logic [16:0] fold_add(logic [16:0] acc, logic [15:0] half);
		logic [17:0] s;
		s = acc + half;
		return s[15:0] + s[17:16];
	endfunction

	function void clear_header();
		word_idx = '0;
		ihl_words = '0;
		csum_acc = '0;
		tot_len = '0;
		ident = '0;
		frag_field = '0;
		proto = '0;
		csum_given = 1'b0;
		src_addr = '0;
		dst_addr = '0;
		frame_len = '0;
	endfunction

	function int pending();
		return verdicts_due.size();
	endfunction

	function void settle(ipv4hc_pkg::verdict_t v);
		ipv4hc_pkg::result_t r;
		r.verdict = v;
		r.protocol_number = proto;
		r.source_address = src_addr;
		r.total_length = tot_len;
		r.header_bytes = {ihl_words, 2'b00};
		r.identification = ident;
		r.fragment_offset_bytes = {frag_field[12:0], 3'b000};
		r.more_fragments = frag_field[13];
		verdicts_due.push_back(r);
		in_header = 1'b0;
	endfunction

	// advance the header state by one accepted word
	function void note_word(logic [31:0] w, logic first, logic [15:0] flen);
		logic [31:0] host;
		logic        dest_ok;
		if (first) begin
			clear_header();
			in_header = 1'b1;
			frame_len = flen;
		end else if (!in_header) begin
			return;
		end
		csum_acc = fold_add(fold_add(csum_acc, w[31:16]), w[15:0]);
		case (word_idx)
			4'd0: begin
				ihl_words = w[27:24];
				tot_len = w[15:0];
				if (w[31:28] != ipv4hc_pkg::IP_VERSION) begin
					settle(ipv4hc_pkg::VERDICT_BAD_VERSION);
					return;
				end
				if (ihl_words < ipv4hc_pkg::MIN_IHL_WORDS ||
				    tot_len < ipv4hc_pkg::MIN_HEADER_BYTES ||
				    frame_len < tot_len) begin
					settle(ipv4hc_pkg::VERDICT_BAD_SIZE);
					return;
				end
			end
			4'd1: begin
				ident = w[31:16];
				frag_field = w[15:0];
			end
			4'd2: begin
				proto = w[23:16];
				csum_given = (w[15:0] != 16'd0);
			end
			4'd3: src_addr = w;
			4'd4: dst_addr = w;
			default: ;
		endcase
		if (int'(word_idx) + 1 < int'(ihl_words)) begin
			word_idx = word_idx + 4'd1;
			return;
		end
		host = ~net_mask;
		dest_ok = (dst_addr == 32'hFFFF_FFFF) ||
			((dst_addr & host) == host && (dst_addr & net_mask) == (local_addr & net_mask)) ||
			(dst_addr == local_addr);
		if (csum_given && csum_acc != {1'b0, ipv4hc_pkg::CSUM_GOOD})
			settle(ipv4hc_pkg::VERDICT_BAD_CSUM);
		else if (!dest_ok)
			settle(ipv4hc_pkg::VERDICT_NOT_OURS);
		else if (frag_field[13:0] != 14'd0)
			settle(ipv4hc_pkg::VERDICT_FRAGMENT);
		else if (proto == ipv4hc_pkg::PROTO_ICMP)
			settle(ipv4hc_pkg::VERDICT_ICMP);
		else if (proto == ipv4hc_pkg::PROTO_UDP)
			settle(ipv4hc_pkg::VERDICT_UDP_UNREACH);
		else if (proto == ipv4hc_pkg::PROTO_TCP)
			settle(ipv4hc_pkg::VERDICT_TCP);
		else
			settle(ipv4hc_pkg::VERDICT_OTHER);
	endfunction

	task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	task check_result(ipv4hc_pkg::result_t got);
		ipv4hc_pkg::result_t want;
		if (verdicts_due.size() == 0) begin
			report_mismatch("verdict with none pending", got.verdict, 0);
			return;
		end
		want = verdicts_due.pop_front();
		if (got.verdict !== want.verdict)
			report_mismatch("verdict", got.verdict, want.verdict);
		if (got.protocol_number !== want.protocol_number)
			report_mismatch("protocol_number", got.protocol_number, want.protocol_number);
		if (got.source_address !== want.source_address)
			report_mismatch("source_address", got.source_address, want.source_address);
		if (got.total_length !== want.total_length)
			report_mismatch("total_length", got.total_length, want.total_length);
		if (got.header_bytes !== want.header_bytes)
			report_mismatch("header_bytes", got.header_bytes, want.header_bytes);
		if (got.identification !== want.identification)
			report_mismatch("identification", got.identification, want.identification);
		if (got.fragment_offset_bytes !== want.fragment_offset_bytes)
			report_mismatch("fragment_offset_bytes", got.fragment_offset_bytes,
				want.fragment_offset_bytes);
		if (got.more_fragments !== want.more_fragments)
			report_mismatch("more_fragments", got.more_fragments, want.more_fragments);
	endtask
endclass

module tb_top;
	localparam int CSUM_OK   = 0;
	localparam int CSUM_ZERO = 1;
	localparam int CSUM_BAD  = 2;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] header_word;
	logic        first_word;
	logic [15:0] frame_length;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  verdict;
	logic [7:0]  protocol_number;
	logic [31:0] source_address;
	logic [15:0] total_length;
	logic [5:0]  header_bytes;
	logic [15:0] identification;
	logic [15:0] fragment_offset_bytes;
	logic        more_fragments;

	header_ledger        ledger;
	ipv4hc_pkg::result_t seen_result;
	logic [31:0]  pkt [0:14];
	logic [15:0]  pkt_flen;
	int           words_sent;
	int           idle_pct;
	int           stall_pct;
	logic         hold_off;

	ipv4_header_receive_checker_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.header_word(header_word),
		.first_word(first_word),
		.frame_length(frame_length),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.verdict(verdict),
		.protocol_number(protocol_number),
		.source_address(source_address),
		.total_length(total_length),
		.header_bytes(header_bytes),
		.identification(identification),
		.fragment_offset_bytes(fragment_offset_bytes),
		.more_fragments(more_fragments)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receive side: take a verdict word when both valid and ready were high at this edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_result.verdict = ipv4hc_pkg::verdict_t'(verdict);
			seen_result.protocol_number = protocol_number;
			seen_result.source_address = source_address;
			seen_result.total_length = total_length;
			seen_result.header_bytes = header_bytes;
			seen_result.identification = identification;
			seen_result.fragment_offset_bytes = fragment_offset_bytes;
			seen_result.more_fragments = more_fragments;
			ledger.check_result(seen_result);
		end
		out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
	end

	task automatic send_word(logic [31:0] w, logic first, logic [15:0] flen);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		header_word <= w;
		first_word <= first;
		frame_length <= flen;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ledger.note_word(w, first, flen);
	endtask

	task automatic send_packet(int n);
		for (int i = 0; i < n; i++)
			send_word(pkt[i], i == 0, pkt_flen);
	endtask

	function automatic logic [31:0] pick_dest(int kind);
		case (kind)
			0: return ledger.local_addr;
			1: return 32'hFFFF_FFFF;
			2: return (ledger.local_addr & ledger.net_mask) | ~ledger.net_mask;
			3: return $urandom;
			default: return ledger.local_addr ^ (32'd1 << $urandom_range(31));
		endcase
	endfunction

	function automatic logic [7:0] pick_proto();
		case ($urandom_range(4))
			0: return ipv4hc_pkg::PROTO_ICMP;
			1: return ipv4hc_pkg::PROTO_UDP;
			2: return ipv4hc_pkg::PROTO_TCP;
			default: return 8'($urandom);
		endcase
	endfunction

	// fill pkt with a well-formed header; the checksum field is set per csum_mode
	task automatic make_header(int ihl, logic [15:0] tl, logic [15:0] flen, logic [31:0] dest,
		logic [7:0] proto, logic [15:0] frag, int csum_mode);
		logic [16:0] sum;
		logic [15:0] good;
		pkt[0] = {ipv4hc_pkg::IP_VERSION, 4'(ihl), 8'($urandom), tl};
		pkt[1] = {16'($urandom), frag};
		pkt[2] = {8'($urandom), proto, 16'h0000};
		pkt[3] = $urandom;
		pkt[4] = dest;
		for (int i = 5; i < 15; i++)
			pkt[i] = $urandom;
		sum = '0;
		for (int i = 0; i < ihl; i++)
			sum = ledger.fold_add(ledger.fold_add(sum, pkt[i][31:16]), pkt[i][15:0]);
		good = ~sum[15:0];
		if (csum_mode == CSUM_OK)
			pkt[2][15:0] = good;
		else if (csum_mode == CSUM_BAD)
			pkt[2][15:0] = good ^ 16'($urandom_range(1, 65535));
		pkt_flen = flen;
	endtask

	task automatic configure(logic [31:0] addr, logic [31:0] mask);
		cfg_write <= 1'b1;
		cfg_index <= ipv4hc_pkg::REG_LOCAL_ADDRESS;
		cfg_data <= addr;
		@(posedge clk);
		cfg_index <= ipv4hc_pkg::REG_SUBNET_MASK;
		cfg_data <= mask;
		@(posedge clk);
		cfg_write <= 1'b0;
		ledger.local_addr = addr;
		ledger.net_mask = mask;
		@(posedge clk);
	endtask

	// drop valid, wait for every verdict, then cover the output register and buffer
	task automatic settle_block();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (ledger.pending() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic directed_checks();
		send_word(32'h0000_0000, 1'b1, 16'h0000);
		send_word(32'hFFFF_FFFF, 1'b1, 16'hFFFF);
		send_word({ipv4hc_pkg::IP_VERSION, 4'd4, 8'h00, 16'd20}, 1'b1, 16'd20);
		send_word({ipv4hc_pkg::IP_VERSION, ipv4hc_pkg::MIN_IHL_WORDS, 8'h00, 16'd19},
			1'b1, 16'd100);
		send_word({ipv4hc_pkg::IP_VERSION, ipv4hc_pkg::MIN_IHL_WORDS, 8'h00, 16'd101},
			1'b1, 16'd100);
		// stray word while idle: no verdict
		send_word(32'h1234_5678, 1'b0, 16'h0000);
		// header cut short by a new first word
		make_header(5, 16'd20, 16'd20, pick_dest(0), ipv4hc_pkg::PROTO_UDP, 16'h0000, CSUM_OK);
		send_packet(2);
		make_header(5, 16'd20, 16'd20, pick_dest(0), ipv4hc_pkg::PROTO_ICMP, 16'h0000,
			CSUM_OK);
		send_packet(5);
		make_header(5, 16'd60, 16'hFFFF, pick_dest(1), ipv4hc_pkg::PROTO_TCP, 16'h4000,
			CSUM_BAD);
		send_packet(5);
		make_header(6, 16'hFFFF, 16'hFFFF, pick_dest(2), ipv4hc_pkg::PROTO_TCP, 16'h4000,
			CSUM_ZERO);
		send_packet(6);
	endtask

	task automatic random_item();
		int pick;
		int ihl;
		int cut;
		int m;
		logic [15:0] tl;
		logic [15:0] fl;
		logic [15:0] frag;
		logic [31:0] w;
		pick = $urandom_range(99);
		if (pick < 80) begin
			ihl = ($urandom_range(4) == 0) ? $urandom_range(7, 15) : $urandom_range(5, 6);
			tl = ($urandom_range(9) < 7) ? 16'($urandom_range(20, 1500))
				: 16'($urandom_range(20, 65535));
			fl = ($urandom_range(3) == 0) ? tl : 16'($urandom_range(tl, 65535));
			frag = ($urandom_range(3) != 0) ? 16'($urandom_range(3)) << 14 : 16'($urandom);
			m = $urandom_range(9);
			make_header(ihl, tl, fl, pick_dest($urandom_range(4)), pick_proto(), frag,
				(m < 6) ? CSUM_OK : (m < 8) ? CSUM_ZERO : CSUM_BAD);
			cut = (pick < 72) ? ihl : $urandom_range(1, ihl - 1);
			send_packet(cut);
			words_sent += cut;
		end else if (pick < 88) begin
			fl = 16'($urandom);
			case ($urandom_range(3))
				0: begin
					w = $urandom;
					if (w[31:28] == ipv4hc_pkg::IP_VERSION)
						w[31:28] = ~w[31:28];
				end
				1: w = {ipv4hc_pkg::IP_VERSION, 4'($urandom_range(4)), 8'($urandom),
					16'($urandom)};
				2: w = {ipv4hc_pkg::IP_VERSION, 4'($urandom_range(5, 15)), 8'($urandom),
					16'($urandom_range(19))};
				default: begin
					tl = 16'($urandom_range(21, 65535));
					fl = 16'($urandom_range(tl - 1));
					w = {ipv4hc_pkg::IP_VERSION, 4'($urandom_range(5, 15)), 8'($urandom), tl};
				end
			endcase
			send_word(w, 1'b1, fl);
			words_sent++;
		end else if (pick < 94) begin
			// words with no first flag; ignored unless a header is open
			repeat ($urandom_range(1, 3))
				send_word($urandom, 1'b0, 16'($urandom));
		end else begin
			send_word($urandom, 1'($urandom_range(1)), 16'($urandom));
			words_sent++;
		end
	endtask

	// close with a complete header so no header stays open across a register write
	task automatic random_run(int count);
		int stop_at;
		stop_at = words_sent + count;
		while (words_sent < stop_at)
			random_item();
		make_header(5, 16'd40, 16'd40, pick_dest($urandom_range(4)), pick_proto(), 16'h0000,
			CSUM_OK);
		send_packet(5);
	endtask

	initial begin
		ledger = new();
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = ipv4hc_pkg::REG_LOCAL_ADDRESS;
		cfg_data = '0;
		in_valid = 1'b0;
		header_word = '0;
		first_word = 1'b0;
		frame_length = '0;
		out_ready = 1'b0;
		hold_off = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		words_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(32'hC0A8_0105, 32'hFFFF_FF00);
		directed_checks();
		random_run(300);
		settle_block();

		idle_pct = 53;
		configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_run(330);
		settle_block();

		idle_pct = 0;
		stall_pct = 53;
		configure(32'h0000_0000, 32'h0000_0000);
		random_run(330);
		settle_block();

		idle_pct = 12;
		stall_pct = 12;
		configure($urandom, ~(32'hFFFF_FFFF >> $urandom_range(32)));
		random_run(330);
		settle_block();

		// hold the receiver off while words keep coming, so the buffer fills
		idle_pct = 0;
		stall_pct = 0;
		configure(32'h0A00_0001, 32'hFF00_0000);
		fork
			begin
				hold_off <= 1'b1;
				repeat (300) @(posedge clk);
				hold_off <= 1'b0;
			end
			random_run(330);
		join
		settle_block();

		configure($urandom, $urandom);
		random_run(330);
		settle_block();

		repeat (10) @(posedge clk);
		if (ledger.pending() != 0)
			ledger.report_mismatch("verdicts never delivered", ledger.pending(), 0);
		if (ledger.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end
endmodule

// ===== ipv4_header_receive_checker_top.f =====
design/ipv4hc_pkg.sv
design/ipv4hc_parse.sv
design/ipv4hc_outbuf.sv
design/ipv4_header_receive_checker_top.sv
design/ipv4hc_checker.sv
tb/tb_top.sv
